/* src/ipd_pkg.sv */
`timescale 1ns / 1ps

package ipd_pkg;

   localparam int NUM_PHASES    = 4;
   localparam int PHASE_W       = 2;
   localparam int SAMPLE_W      = 10;
   localparam int LEVEL_W       = 10;
   localparam int AVG_LEN_W     = 7;
   localparam int RANGE_W       = 9;
   localparam int WARMUP_W      = 16;
   localparam int COUNT_W       = 16;
   localparam int TONE_W        = 16;
   localparam int CSR_ADDR_W    = 2;
   localparam int CSR_DATA_W    = 16;
   localparam int DIVISOR_W     = LEVEL_W + 1;
   localparam int DEF_FRAC_BITS = 8;

   localparam logic [AVG_LEN_W-1:0] AVG_LEN_RESET   = 7'd20;
   localparam logic [RANGE_W-1:0]   MAX_RANGE_RESET = 9'd30;
   localparam logic [WARMUP_W-1:0]  WARMUP_RESET    = 16'd100;

   localparam logic [RANGE_W-1:0]   RANGE_NUMERATOR = 9'd500;
   localparam logic [RANGE_W:0]     TONE_OFFSET     = 10'd20;
   localparam logic [6:0]           TONE_SCALE      = 7'd100;
   localparam logic [LEVEL_W-1:0]   ADC_MAX         = 10'd1023;
   localparam logic [COUNT_W-1:0]   COUNT_MAX       = 16'hFFFF;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_AVG_LENGTH     = 2'd0,
      CSR_MAX_RANGE      = 2'd1,
      CSR_WARMUP_SAMPLES = 2'd2,
      CSR_TONE_ENABLE    = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [PHASE_W-1:0]  phase_index;
      logic [SAMPLE_W-1:0] sample;
   } req_type;

   typedef struct packed {
      logic                led_on;
      logic [LEVEL_W-1:0]  signal_level;
      logic [RANGE_W-1:0]  range_cm;
      logic [TONE_W-1:0]   tone_freq;
      logic [LEVEL_W-1:0]  ambient_level;
   } rsp_type;

   typedef struct packed {
      logic [CSR_ADDR_W-1:0] index;
      logic [CSR_DATA_W-1:0] data;
   } csr_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL,
      ST_DIV_AVG,
      ST_WRITEBACK,
      ST_EXTREMES,
      ST_DIV_RANGE,
      ST_RANGE,
      ST_TONE,
      ST_OUT
   } state_type;

endpackage

/* src/ipd_chan_if.sv */
`timescale 1ns / 1ps

interface ipd_chan_if #(
   parameter type payload_type = logic
) ();
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

/* src/ir_four_phase_proximity_detector.sv */
`timescale 1ns / 1ps

// channel   direction  payload
// req_if    in         phase_index, sample
// rsp_if    out        led_on, signal_level, range_cm, tone_freq, ambient_level
// csr_if    in         index, data (always ready)
//
// req_if is ready only in idle, so a transaction runs to the final load before
// the next is accepted; most of it is spent in the shared restoring divider: it
// runs FRAC_BITS + 17 steps for the average and 9 steps for the range
// synchronous reset clears the averages, the sample count and the output valid
// a result waiting in the output register stalls only the final load step

module ir_four_phase_proximity_detector #(
   parameter int FRAC_BITS = ipd_pkg::DEF_FRAC_BITS
) (
   input  logic       clock,
   input  logic       reset,
   ipd_chan_if.sink   req_if,
   ipd_chan_if.source rsp_if,
   ipd_chan_if.sink   csr_if
);
   import ipd_pkg::*;

   localparam int AVG_W = SAMPLE_W + FRAC_BITS;
   localparam int NUM_W = AVG_W + AVG_LEN_W;
   localparam int CNT_W = $clog2(NUM_W + 1);

   state_type state_ff, state_in;

   logic [AVG_LEN_W-1:0] avg_length_ff;
   logic [RANGE_W-1:0]   max_range_ff;
   logic [WARMUP_W-1:0]  warmup_ff;
   logic                 tone_enable_ff;

   logic [AVG_W-1:0]     avg_ff [NUM_PHASES];
   logic [COUNT_W-1:0]   count_ff, count_in;

   logic [PHASE_W-1:0]   ph_ff, ph_in;
   logic [SAMPLE_W-1:0]  smp_ff, smp_in;

   // shared divider: dividend shifts out the top, quotient bits shift in
   logic [NUM_W-1:0]     dq_ff, dq_in;
   logic [DIVISOR_W-1:0] rem_ff, rem_in;
   logic [DIVISOR_W-1:0] div_ff, div_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;

   logic [AVG_W-1:0]     hi_ff, hi_in;
   logic [LEVEL_W-1:0]   sig_ff, sig_in;
   logic [RANGE_W-1:0]   range_ff, range_in;
   logic [TONE_W-1:0]    tone_ff, tone_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_ff, rsp_in;

   logic                 avg_we;
   logic                 req_fire;

   logic [DIVISOR_W:0]   trial;
   logic [DIVISOR_W:0]   trial_diff;
   logic                 trial_ge;
   logic [AVG_LEN_W-1:0] n_minus_1;
   logic [NUM_W-1:0]     numerator;
   logic [AVG_W-1:0]     ext_hi, ext_lo;
   logic [AVG_W-1:0]     ext_span;
   logic [RANGE_W-1:0]   quot;
   logic [RANGE_W:0]     tone_base;
   logic [RANGE_W+7:0]   tone_prod;

   assign req_if.ready  = (state_ff == ST_IDLE);
   assign req_fire      = req_if.valid && req_if.ready;
   assign csr_if.ready  = 1'b1;
   assign rsp_if.valid  = rsp_valid_ff;
   assign rsp_if.payload = rsp_ff;

   // divider step
   always_comb begin
      trial      = {rem_ff, dq_ff[NUM_W-1]};
      trial_diff = trial - {1'b0, div_ff};
      trial_ge   = (trial >= {1'b0, div_ff});
   end

   // average numerator; avg_length of 0 or 1 means N = 1
   always_comb begin
      n_minus_1 = (avg_length_ff <= AVG_LEN_W'(1)) ? '0 : avg_length_ff - AVG_LEN_W'(1);
      numerator = NUM_W'(avg_ff[ph_ff]) * NUM_W'(n_minus_1)
                + (NUM_W'(smp_ff) << FRAC_BITS);
   end

   always_comb begin
      ext_hi = avg_ff[0];
      ext_lo = avg_ff[0];
      for (int i = 1; i < NUM_PHASES; i++) begin
         if (avg_ff[i] > ext_hi) ext_hi = avg_ff[i];
         if (avg_ff[i] < ext_lo) ext_lo = avg_ff[i];
      end
      ext_span = ext_hi - ext_lo;
   end

   always_comb begin
      quot      = dq_ff[RANGE_W-1:0];
      tone_base = {1'b0, max_range_ff} - {1'b0, range_ff} + TONE_OFFSET;
      tone_prod = tone_base * TONE_SCALE;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:      if (req_fire) state_in = ST_MUL;
         ST_MUL:       state_in = ST_DIV_AVG;
         ST_DIV_AVG:   if (cnt_ff == CNT_W'(1)) state_in = ST_WRITEBACK;
         ST_WRITEBACK: state_in = ST_EXTREMES;
         ST_EXTREMES:  state_in = ST_DIV_RANGE;
         ST_DIV_RANGE: if (cnt_ff == CNT_W'(1)) state_in = ST_RANGE;
         ST_RANGE:     state_in = ST_TONE;
         ST_TONE:      state_in = ST_OUT;
         ST_OUT:       if (!rsp_valid_ff || rsp_if.ready) state_in = ST_IDLE;
         default:      state_in = ST_IDLE;
      endcase
   end

   // datapath controls
   always_comb begin
      ph_in        = ph_ff;
      smp_in       = smp_ff;
      dq_in        = dq_ff;
      rem_in       = rem_ff;
      div_in       = div_ff;
      cnt_in       = cnt_ff;
      hi_in        = hi_ff;
      sig_in       = sig_ff;
      range_in     = range_ff;
      tone_in      = tone_ff;
      count_in     = count_ff;
      avg_we       = 1'b0;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               ph_in  = req_if.payload.phase_index;
               smp_in = req_if.payload.sample;
            end
         end
         ST_MUL: begin
            dq_in  = numerator;
            rem_in = '0;
            div_in = (avg_length_ff == '0) ? DIVISOR_W'(1) : DIVISOR_W'(avg_length_ff);
            cnt_in = CNT_W'(NUM_W);
         end
         ST_DIV_AVG, ST_DIV_RANGE: begin
            dq_in  = {dq_ff[NUM_W-2:0], trial_ge};
            rem_in = trial_ge ? trial_diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
            cnt_in = cnt_ff - CNT_W'(1);
         end
         ST_WRITEBACK: begin
            avg_we = 1'b1;
            if (count_ff != COUNT_MAX) count_in = count_ff + COUNT_W'(1);
         end
         ST_EXTREMES: begin
            hi_in  = ext_hi;
            sig_in = (count_ff < warmup_ff) ? '0 : ext_span[AVG_W-1:FRAC_BITS];
            dq_in  = NUM_W'(RANGE_NUMERATOR) << (NUM_W - RANGE_W);
            rem_in = '0;
            div_in = DIVISOR_W'(sig_in) + DIVISOR_W'(1);
            cnt_in = CNT_W'(RANGE_W);
         end
         ST_RANGE: begin
            range_in = (quot < max_range_ff) ? quot + RANGE_W'(1) : '0;
         end
         ST_TONE: begin
            tone_in = (tone_enable_ff && range_ff != '0) ? tone_prod[TONE_W-1:0] : '0;
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_if.ready) begin
               rsp_valid_in         = 1'b1;
               rsp_in.led_on        = (ph_ff < PHASE_W'(2));
               rsp_in.signal_level  = sig_ff;
               rsp_in.range_cm      = range_ff;
               rsp_in.tone_freq     = tone_ff;
               rsp_in.ambient_level = ADC_MAX - hi_ff[AVG_W-1:FRAC_BITS];
            end
         end
         default: begin
            rsp_valid_in = rsp_valid_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         avg_length_ff  <= AVG_LEN_RESET;
         max_range_ff   <= MAX_RANGE_RESET;
         warmup_ff      <= WARMUP_RESET;
         tone_enable_ff <= 1'b1;
         count_ff       <= '0;
         rsp_valid_ff   <= 1'b0;
         for (int i = 0; i < NUM_PHASES; i++) begin
            avg_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         if (avg_we) avg_ff[ph_ff] <= dq_ff[AVG_W-1:0];
         if (csr_if.valid) begin
            case (csr_index_type'(csr_if.payload.index))
               CSR_AVG_LENGTH:     avg_length_ff  <= csr_if.payload.data[AVG_LEN_W-1:0];
               CSR_MAX_RANGE:      max_range_ff   <= csr_if.payload.data[RANGE_W-1:0];
               CSR_WARMUP_SAMPLES: warmup_ff      <= csr_if.payload.data[WARMUP_W-1:0];
               CSR_TONE_ENABLE:    tone_enable_ff <= csr_if.payload.data[0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      ph_ff    <= ph_in;
      smp_ff   <= smp_in;
      dq_ff    <= dq_in;
      rem_ff   <= rem_in;
      div_ff   <= div_in;
      cnt_ff   <= cnt_in;
      hi_ff    <= hi_in;
      sig_ff   <= sig_in;
      range_ff <= range_in;
      tone_ff  <= tone_in;
      rsp_ff   <= rsp_in;
   end

endmodule
